### rtl/core/spfel_pkg.sv
// Package for the slot pool allocator: sizes, codes, payload structs and the
// command/status structs between controller and datapath. No dependencies.
`default_nettype none

package spfel_pkg;

  // Pool size and derived widths
  localparam int unsigned SLOTS = 64;
  localparam int unsigned SlotW = $clog2(SLOTS);
  localparam int unsigned LinkW = $clog2(SLOTS + 1);
  localparam int unsigned CondW = 2;
  localparam logic [LinkW-1:0] NullLink = LinkW'(SLOTS);

  typedef enum logic [1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_MARK    = 2'd2,
    KIND_TAKE    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_WRONG = 2'd2
  } status_e;

  typedef enum logic [CondW-1:0] {
    COND_FREE = 2'd0,
    COND_USED = 2'd1,
    COND_ERR  = 2'd2
  } cond_e;

  typedef enum logic {
    LIST_FREE = 1'b0,
    LIST_ERR  = 1'b1
  } list_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_CAPT,
    S_DECIDE,
    S_UNL_A,
    S_UNL_B,
    S_PUSH_A,
    S_PUSH_B,
    S_FINISH
  } state_e;

  // Input transaction
  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] slot_index;
  } req_t;

  // Result transaction
  typedef struct packed {
    logic [6:0] granted_slot;
    logic [1:0] status;
    logic [6:0] free_count;
  } result_t;

  // Controller to datapath commands
  typedef struct packed {
    logic    latch;
    logic    rd;
    logic    cap;
    logic    unl_a;
    logic    unl_b;
    logic    push_a;
    logic    push_b;
    logic    finish;
    list_e   list;
    status_e status;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    kind_e kind;
    cond_e cond;
    logic  free_empty;
    logic  err_empty;
    logic  slot_bad;
  } dp_stat_t;

endpackage

`default_nettype wire

### rtl/core/spfel_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module spfel_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/core/spfel_ctrl.sv
// Sequencer for the slot pool: walks each transaction through read, capture,
// decide, then unlink and push steps as needed, and finish. Depends on spfel_pkg.
`default_nettype none

module spfel_ctrl import spfel_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  output logic          busy,
  input  wire dp_stat_t stat_i,
  output dp_cmd_t       ctl_o
);

  state_e  state_q, state_d;
  status_e st_q, st_d;
  status_e dec_st;
  list_e   unl_list;
  list_e   push_list;
  logic    need_push;

  // Derive list selection and outcome from the latched transaction
  always_comb begin
    unl_list  = LIST_ERR;
    push_list = LIST_ERR;
    need_push = 1'b0;
    dec_st    = ST_OK;
    unique case (stat_i.kind)
      KIND_ALLOC: begin
        unl_list = LIST_FREE;
        if (stat_i.free_empty) dec_st = ST_EMPTY;
      end
      KIND_RELEASE: begin
        push_list = LIST_FREE;
        need_push = 1'b1;
        if (stat_i.slot_bad || (stat_i.cond != COND_USED)) dec_st = ST_WRONG;
      end
      KIND_MARK: begin
        unl_list  = (stat_i.cond == COND_FREE) ? LIST_FREE : LIST_ERR;
        need_push = 1'b1;
        if (stat_i.slot_bad) dec_st = ST_WRONG;
      end
      KIND_TAKE: begin
        if (stat_i.err_empty) dec_st = ST_EMPTY;
      end
      default: begin
        dec_st = ST_WRONG;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    st_d    = st_q;
    unique case (state_q)
      S_IDLE:   if (start) state_d = S_READ;
      S_READ:   state_d = S_CAPT;
      S_CAPT:   state_d = S_DECIDE;
      S_DECIDE: begin
        st_d = dec_st;
        if (dec_st != ST_OK) begin
          state_d = S_FINISH;
        end else begin
          unique case (stat_i.kind)
            KIND_ALLOC, KIND_TAKE: state_d = S_UNL_A;
            KIND_RELEASE:          state_d = S_PUSH_A;
            KIND_MARK: state_d = (stat_i.cond == COND_USED) ? S_PUSH_A : S_UNL_A;
            default:               state_d = S_FINISH;
          endcase
        end
      end
      S_UNL_A:  state_d = S_UNL_B;
      S_UNL_B:  state_d = need_push ? S_PUSH_A : S_FINISH;
      S_PUSH_A: state_d = S_PUSH_B;
      S_PUSH_B: state_d = S_FINISH;
      S_FINISH: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Command outputs
  always_comb begin
    ctl_o        = '0;
    ctl_o.list   = ((state_q == S_UNL_A) || (state_q == S_UNL_B)) ? unl_list : push_list;
    ctl_o.status = st_q;
    unique case (state_q)
      S_IDLE:   ctl_o.latch  = start;
      S_READ:   ctl_o.rd     = 1'b1;
      S_CAPT:   ctl_o.cap    = 1'b1;
      S_DECIDE: ;
      S_UNL_A:  ctl_o.unl_a  = 1'b1;
      S_UNL_B:  ctl_o.unl_b  = 1'b1;
      S_PUSH_A: ctl_o.push_a = 1'b1;
      S_PUSH_B: ctl_o.push_b = 1'b1;
      S_FINISH: ctl_o.finish = 1'b1;
      default:  ;
    endcase
  end

  assign busy = (state_q != S_IDLE);

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      st_q    <= ST_OK;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
    end
  end

  // A transaction always ends through the finish step
  a_busy_ends_in_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> ($past(state_q) == S_FINISH))
    else $error("busy dropped without a finish step");

  // At most one datapath step per cycle
  a_one_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctl_o.rd, ctl_o.cap, ctl_o.unl_a, ctl_o.unl_b,
              ctl_o.push_a, ctl_o.push_b, ctl_o.finish}))
    else $error("more than one datapath step issued");

endmodule

`default_nettype wire

### rtl/core/spfel_dp.sv
// Datapath for the slot pool: link and condition memories with valid bits,
// list heads, free count and the result register. Depends on spfel_pkg, spfel_ram.
`default_nettype none

module spfel_dp import spfel_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire req_t    req_i,
  input  wire dp_cmd_t ctl_i,
  output dp_stat_t     stat_o,
  output logic         result_valid_o,
  output result_t      result_o
);

  // Reset contents of the link memories
  function automatic logic [LinkW-1:0] reset_next(input logic [SlotW-1:0] idx);
    return LinkW'(idx) + LinkW'(1);
  endfunction

  function automatic logic [LinkW-1:0] reset_prev(input logic [SlotW-1:0] idx);
    return (idx == '0) ? NullLink : (LinkW'(idx) - LinkW'(1));
  endfunction

  kind_e            kind_q;
  logic [5:0]       slot_in_q;
  logic [LinkW-1:0] s_q, p_q, n_q, h_q;
  cond_e            c_q;
  logic             rv_next_q, rv_prev_q, rv_cond_q;

  logic [LinkW-1:0] free_head_q, free_head_d;
  logic [LinkW-1:0] err_head_q, err_head_d;
  logic [LinkW-1:0] free_total_q, free_total_d;
  logic [SLOTS-1:0] next_vld_q, prev_vld_q, cond_vld_q;
  logic             result_valid_q;
  result_t          result_q, result_d;

  logic [LinkW-1:0] rd_slot;
  logic [SlotW-1:0] rd_addr;
  logic [SlotW-1:0] s_idx;
  logic [LinkW-1:0] h_cur;
  logic             ok;
  cond_e            cond_new;
  logic [LinkW-1:0] granted;

  logic             next_we, prev_we, cond_we;
  logic [SlotW-1:0] next_waddr, prev_waddr;
  logic [LinkW-1:0] next_wdata, prev_wdata;
  logic [LinkW-1:0] next_rdata, prev_rdata;
  logic [CondW-1:0] cond_rdata;

  assign s_idx = s_q[SlotW-1:0];
  assign h_cur = (ctl_i.list == LIST_FREE) ? free_head_q : err_head_q;
  assign ok    = (ctl_i.status == ST_OK);

  // Select the slot to read: list head for pops, the given slot otherwise
  always_comb begin
    case (kind_q)
      KIND_ALLOC: rd_slot = free_head_q;
      KIND_TAKE:  rd_slot = err_head_q;
      default:    rd_slot = LinkW'(slot_in_q);
    endcase
  end
  assign rd_addr = rd_slot[SlotW-1:0];

  // Status toward the controller
  always_comb begin
    stat_o.kind       = kind_q;
    stat_o.cond       = c_q;
    stat_o.free_empty = (free_total_q == '0) || (free_head_q == NullLink);
    stat_o.err_empty  = (err_head_q == NullLink);
    stat_o.slot_bad   = (LinkW'(slot_in_q) >= NullLink);
  end

  // Write ports of the link memories
  always_comb begin
    next_we    = 1'b0;
    next_waddr = s_idx;
    next_wdata = NullLink;
    prev_we    = 1'b0;
    prev_waddr = s_idx;
    prev_wdata = NullLink;
    if (ctl_i.unl_a) begin
      if (p_q != NullLink) begin
        next_we    = 1'b1;
        next_waddr = p_q[SlotW-1:0];
        next_wdata = n_q;
      end
      if (n_q != NullLink) begin
        prev_we    = 1'b1;
        prev_waddr = n_q[SlotW-1:0];
        prev_wdata = p_q;
      end
    end
    if (ctl_i.unl_b) begin
      next_we = 1'b1;
      prev_we = 1'b1;
    end
    if (ctl_i.push_a) begin
      next_we    = 1'b1;
      next_wdata = h_cur;
      prev_we    = 1'b1;
    end
    if (ctl_i.push_b && (h_q != NullLink)) begin
      prev_we    = 1'b1;
      prev_waddr = h_q[SlotW-1:0];
      prev_wdata = s_q;
    end
  end

  // List heads: unlink of a head slot, or push of a new head
  always_comb begin
    free_head_d = free_head_q;
    err_head_d  = err_head_q;
    if (ctl_i.unl_a && (p_q == NullLink)) begin
      if (ctl_i.list == LIST_FREE) free_head_d = n_q;
      else                         err_head_d  = n_q;
    end else if (ctl_i.push_a) begin
      if (ctl_i.list == LIST_FREE) free_head_d = s_q;
      else                         err_head_d  = s_q;
    end
  end

  // Commit condition, free count and result at finish
  always_comb begin
    case (kind_q)
      KIND_ALLOC, KIND_TAKE: cond_new = COND_USED;
      KIND_RELEASE:          cond_new = COND_FREE;
      default:               cond_new = COND_ERR;
    endcase
    cond_we      = ctl_i.finish && ok;
    free_total_d = free_total_q;
    if (ctl_i.finish && ok) begin
      case (kind_q)
        KIND_ALLOC:   free_total_d = free_total_q - LinkW'(1);
        KIND_RELEASE: free_total_d = free_total_q + LinkW'(1);
        KIND_MARK: begin
          if ((c_q == COND_FREE) && (free_total_q != '0)) begin
            free_total_d = free_total_q - LinkW'(1);
          end
        end
        default: ;
      endcase
    end
    granted = (ok && ((kind_q == KIND_ALLOC) || (kind_q == KIND_TAKE))) ? s_q : NullLink;
    result_d.granted_slot = 7'(granted);
    result_d.status       = ctl_i.status;
    result_d.free_count   = 7'(free_total_d);
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_head_q    <= '0;
      err_head_q     <= NullLink;
      free_total_q   <= LinkW'(SLOTS);
      next_vld_q     <= '0;
      prev_vld_q     <= '0;
      cond_vld_q     <= '0;
      result_valid_q <= 1'b0;
    end else begin
      free_head_q    <= free_head_d;
      err_head_q     <= err_head_d;
      free_total_q   <= free_total_d;
      result_valid_q <= ctl_i.finish;
      if (next_we) next_vld_q[next_waddr] <= 1'b1;
      if (prev_we) prev_vld_q[prev_waddr] <= 1'b1;
      if (cond_we) cond_vld_q[s_idx]      <= 1'b1;
    end
  end

  // Transaction payload and read captures
  always_ff @(posedge clk_i) begin
    if (ctl_i.latch) begin
      kind_q    <= kind_e'(req_i.kind);
      slot_in_q <= req_i.slot_index;
    end
    if (ctl_i.rd) begin
      s_q       <= rd_slot;
      rv_next_q <= next_vld_q[rd_addr];
      rv_prev_q <= prev_vld_q[rd_addr];
      rv_cond_q <= cond_vld_q[rd_addr];
    end
    if (ctl_i.cap) begin
      n_q <= rv_next_q ? next_rdata : reset_next(s_idx);
      p_q <= rv_prev_q ? prev_rdata : reset_prev(s_idx);
      c_q <= rv_cond_q ? cond_e'(cond_rdata) : COND_FREE;
    end
    if (ctl_i.push_a) begin
      h_q <= h_cur;
    end
    if (ctl_i.finish) begin
      result_q <= result_d;
    end
  end

  spfel_ram #(.Width(LinkW), .Depth(SLOTS)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (next_we),
    .waddr_i (next_waddr),
    .wdata_i (next_wdata),
    .re_i    (ctl_i.rd),
    .raddr_i (rd_addr),
    .rdata_o (next_rdata)
  );

  spfel_ram #(.Width(LinkW), .Depth(SLOTS)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (prev_we),
    .waddr_i (prev_waddr),
    .wdata_i (prev_wdata),
    .re_i    (ctl_i.rd),
    .raddr_i (rd_addr),
    .rdata_o (prev_rdata)
  );

  spfel_ram #(.Width(CondW), .Depth(SLOTS)) u_cond_ram (
    .clk_i   (clk_i),
    .we_i    (cond_we),
    .waddr_i (s_idx),
    .wdata_i (cond_new),
    .re_i    (ctl_i.rd),
    .raddr_i (rd_addr),
    .rdata_o (cond_rdata)
  );

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

  // Free count never exceeds the pool
  a_total_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_total_q <= LinkW'(SLOTS))
    else $error("free count above pool size");

  // Between transactions the free count and free head agree on emptiness
  a_free_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.latch |-> ((free_total_q == '0) == (free_head_q == NullLink)))
    else $error("free count and free head disagree");

  // Never unlink the null slot
  a_unlink_real: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.unl_a |-> (s_q != NullLink))
    else $error("unlink of null slot");

endmodule

`default_nettype wire

### rtl/core/slot_pool_free_and_error_lists.sv
// Slot pool allocator with free and error lists, one transaction at a time.
// Steps after accept, set by the sequencer: read, capture, decide; a failed
// operation then finishes. Otherwise allocate and take error unlink, release
// and mark error of an in-use slot push, mark error of a listed slot unlinks
// then pushes, and all finish; start is taken again in the cycle the strobe shows.
// Reset: all slots free in order, slot 0 at the free head; no clearing pass.
`default_nettype none

module slot_pool_free_and_error_lists import spfel_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  output logic      busy,
  input  wire req_t req_i,
  output logic      result_valid_o,
  output result_t   result_o
);

  dp_cmd_t  ctl;
  dp_stat_t stat;

  // Sequencer
  spfel_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .ctl_o  (ctl)
  );

  // Lists, memories and result register
  spfel_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req_i),
    .ctl_i          (ctl),
    .stat_o         (stat),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

`default_nettype wire
